// ===== rtl/strb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strb_pkg
// shared constants for the scrolling text ring buffer
// ----------------------------------------------------------------------------
package strb_pkg;

  // default geometry of the text box
  localparam int DEF_MAX_COLS = 14;
  localparam int DEF_MAX_ROWS = 6;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int LW_W    = 4;  // line_width register
  localparam int LC_W    = 3;  // line_count register
  localparam int ORG_W   = 8;  // origin registers
  localparam int LINE_W  = 3;  // read_line
  localparam int POS_W   = 4;  // read_pos
  localparam int PROD_W  = LW_W + LC_W;

  // stream beat packing
  localparam int IN_DATA_W  = 16;  // char_in, read_line, read_pos, pad
  localparam int OUT_DATA_W = 24;  // char_out, col_addr, row_addr

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW = 8'd3;

  // character codes
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'h0d;

  // display columns advance by 8 per position
  localparam int COL_STEP_SHIFT = 3;

  // input kinds carried in tuser
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

endpackage

// ===== rtl/strb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strb_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module strb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 84
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scrolling_text_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_text_ring_buffer
// character text box kept as a ring of line_width x line_count cells
// ----------------------------------------------------------------------------
// usage
//   s_axis: one beat per command. tuser selects append (0) or read (1).
//     append: char_in is stored at the write index and the index advances;
//     carriage return is dropped, newline pads spaces to the end of the line
//     and the oldest-line head moves on when the writer catches up with it.
//     read: returns the cell at (read_line, read_pos) counted from the head.
//   m_axis: one beat per read, none for an append. tdata holds char_out,
//     col_addr and row_addr; tuser holds in_range. out-of-range reads give a
//     space with in_range low.
//   cfg: index/data write channel, always ready. writing line_width or
//     line_count wipes the box to spaces (clears the per-cell valid bits).
// timing
//   append: the cell is written in the cycle the beat is accepted.
//   newline: up to line_width cells, one cell written per cycle through
//     the single ram write port. read: offset register, address add with
//     ram read, then output register; s_axis is ready again in the cycle
//     the result lands; a new read is not taken until the last one leaves
//     its read stages. the output register lets a new command in while a
//     read result waits; if the receiver stalls, a second read holds in
//     its last stage until the output register frees up.
// reset
//   synchronous rst: full-size box, origins zero, all cells blank,
//   write index 0, head at the last cell.
// ----------------------------------------------------------------------------
module scrolling_text_ring_buffer #(
  parameter int MAX_COLS = strb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = strb_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  // command stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_in, [10:8] read_line, [14:11] read_pos, [15] zero
  input  logic [strb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] op
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] char_out, [15:8] col_addr, [23:16] row_addr
  output logic [strb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] in_range
  output logic                              m_axis_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [strb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [strb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import strb_pkg::*;

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SZ_W    = $clog2(DEPTH + 1);
  localparam int SUM_W   = ((IDX_W > PROD_W) ? IDX_W : PROD_W) + 1;
  // register reset values, limited to what the register widths can hold
  localparam int RST_COLS = (MAX_COLS > 15) ? 15 : MAX_COLS;
  localparam int RST_ROWS = (MAX_ROWS > 7) ? 7 : MAX_ROWS;
  localparam int RST_SIZE = RST_COLS * RST_ROWS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_ADDR = 4'b0100,
    S_DATA = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [LW_W-1:0]  line_width;
  logic [LC_W-1:0]  line_count;
  logic [ORG_W-1:0] origin_col;
  logic [ORG_W-1:0] origin_row;
  logic [SZ_W-1:0]  buf_size;

  // ring pointers; wr_col tracks write_index mod line_width
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] oldest_head;
  logic [LW_W-1:0]  wr_col;
  logic [DEPTH-1:0] cell_valid;

  // command fields
  logic             in_op;
  logic [CHAR_W-1:0] in_char;
  logic [LINE_W-1:0] in_line;
  logic [POS_W-1:0]  in_pos;
  logic              s_beat;

  assign in_op   = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_line = s_axis_tdata[10:8];
  assign in_pos  = s_axis_tdata[14:11];
  assign s_beat  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // held read request
  logic [LINE_W-1:0] rd_line;
  logic [POS_W-1:0]  rd_pos;
  logic              rd_ok;
  logic [PROD_W-1:0] rd_offset;   // line * line_width + pos
  logic              rd_cell_ok;  // in range and cell written since clear

  // ---------------------------------------------------------------------
  // one ring step: store a cell, advance the writer, push the head
  // ---------------------------------------------------------------------
  logic              put_en;
  logic [CHAR_W-1:0] put_char;
  logic [SZ_W:0]     widx_plus;
  logic [IDX_W-1:0]  widx_inc;
  logic [SZ_W:0]     head_plus;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_after;
  logic [LW_W:0]     col_plus;
  logic [LW_W-1:0]   col_inc;

  always_comb begin
    widx_plus  = (SZ_W + 1)'(write_index) + 1'b1;
    widx_inc   = (widx_plus >= {1'b0, buf_size}) ? '0 : IDX_W'(widx_plus);
    head_plus  = (SZ_W + 1)'(oldest_head) + 1'b1;
    head_inc   = (head_plus >= {1'b0, buf_size}) ? '0 : IDX_W'(head_plus);
    head_after = (widx_inc == oldest_head) ? head_inc : oldest_head;
    col_plus   = {1'b0, wr_col} + 1'b1;
    col_inc    = (col_plus == {1'b0, line_width}) ? '0 : LW_W'(col_plus);
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  logic out_load;
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    put_en     = 1'b0;
    put_char   = SPACE_CHAR;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_beat) begin
          if (in_op == OP_READ) begin
            state_next = S_ADDR;
          end else if (in_char == NEWLINE_CHAR) begin
            state_next = S_FILL;
          end else if (in_char != RETURN_CHAR) begin
            put_en   = 1'b1;
            put_char = in_char;
          end
        end
      end
      S_FILL: begin
        put_en = 1'b1;
        if (col_inc == '0) begin
          state_next = S_IDLE;
        end
      end
      S_ADDR: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // read address: head + offset, folded once around the ring
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] rd_sum;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    rd_sum  = SUM_W'(oldest_head) + SUM_W'(rd_offset);
    rd_addr = (rd_sum >= SUM_W'(buf_size)) ? IDX_W'(rd_sum - SUM_W'(buf_size))
                                           : IDX_W'(rd_sum);
  end

  logic [CHAR_W-1:0] ram_rdata;

  strb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (put_en),
    .waddr (write_index),
    .wdata (put_char),
    .re    (state == S_ADDR),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // configuration decode with clamping of the size registers
  // ---------------------------------------------------------------------
  logic              cfg_beat;
  logic [LW_W-1:0]   cfg_lw;
  logic [LC_W-1:0]   cfg_lc;
  logic [LW_W-1:0]   new_lw;
  logic [LC_W-1:0]   new_lc;
  logic [PROD_W-1:0] new_prod;
  logic              size_wr;

  assign cfg_beat = cfg_valid && cfg_ready;

  always_comb begin
    cfg_lw = cfg_data[LW_W-1:0];
    if (int'(cfg_lw) > MAX_COLS) cfg_lw = LW_W'(MAX_COLS);
    if (cfg_lw == '0) cfg_lw = LW_W'(1);
    cfg_lc = cfg_data[LC_W-1:0];
    if (int'(cfg_lc) > MAX_ROWS) cfg_lc = LC_W'(MAX_ROWS);
    if (cfg_lc == '0) cfg_lc = LC_W'(1);

    new_lw  = line_width;
    new_lc  = line_count;
    size_wr = 1'b0;
    if (cfg_beat && cfg_index == REG_LINE_WIDTH) begin
      new_lw  = cfg_lw;
      size_wr = 1'b1;
    end
    if (cfg_beat && cfg_index == REG_LINE_COUNT) begin
      new_lc  = cfg_lc;
      size_wr = 1'b1;
    end
    new_prod = PROD_W'(new_lw) * PROD_W'(new_lc);
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      line_width    <= LW_W'(RST_COLS);
      line_count    <= LC_W'(RST_ROWS);
      origin_col    <= '0;
      origin_row    <= '0;
      buf_size      <= SZ_W'(RST_SIZE);
      write_index   <= '0;
      oldest_head   <= IDX_W'(RST_SIZE - 1);
      wr_col        <= '0;
      cell_valid    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_beat) begin
        if (cfg_index == REG_ORIGIN_COL) origin_col <= cfg_data[ORG_W-1:0];
        if (cfg_index == REG_ORIGIN_ROW) origin_row <= cfg_data[ORG_W-1:0];
      end
      // size change wipes the box
      if (size_wr) begin
        line_width  <= new_lw;
        line_count  <= new_lc;
        buf_size    <= SZ_W'(new_prod);
        write_index <= '0;
        oldest_head <= IDX_W'(SZ_W'(new_prod) - 1'b1);
        wr_col      <= '0;
        cell_valid  <= '0;
      end else if (put_en) begin
        cell_valid[write_index] <= 1'b1;
        write_index <= widx_inc;
        oldest_head <= head_after;
        wr_col      <= col_inc;
      end
    end
  end

  // read request and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_beat) begin
      rd_line   <= in_line;
      rd_pos    <= in_pos;
      rd_ok     <= ({1'b0, in_line} < {1'b0, line_count}) && (in_pos < line_width);
      rd_offset <= PROD_W'(in_line) * PROD_W'(line_width) + PROD_W'(in_pos);
    end
    if (state == S_ADDR) begin
      rd_cell_ok <= rd_ok && cell_valid[rd_addr];
    end
    if (out_load) begin
      m_axis_tdata[7:0]   <= rd_cell_ok ? ram_rdata : SPACE_CHAR;
      m_axis_tdata[15:8]  <= origin_col + ORG_W'({rd_pos, {COL_STEP_SHIFT{1'b0}}});
      m_axis_tdata[23:16] <= origin_row + ORG_W'(rd_line);
      m_axis_tuser        <= rd_ok;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_widx_in_ring: assert property (@(posedge clk) disable iff (rst)
    SZ_W'(write_index) < buf_size)
    else $error("write index outside ring");

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    SZ_W'(oldest_head) < buf_size)
    else $error("head outside ring");

  a_col_in_line: assert property (@(posedge clk) disable iff (rst)
    wr_col < line_width)
    else $error("write column past line width");

  a_fill_ends_at_line_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && state_next == S_IDLE) |=> (wr_col == '0))
    else $error("newline fill ended mid-line");

  a_result_only_after_read: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state == S_ADDR) || $past(state == S_DATA))
    else $error("result loaded without a read");

endmodule
